// ===== design/bwsc_pkg.sv =====
// Shared types, constants and cost functions for the bus wait-state cycle calculator.
// Depends on nothing; every other file of the block imports it.
package bwsc_pkg;

    localparam int DEF_MAX_PREFETCH_LOADS = 8;

    // Address regions, taken from address bits 27:24.
    localparam logic [3:0] REGION_EWRAM   = 4'h2;
    localparam logic [3:0] REGION_PALETTE = 4'h5;
    localparam logic [3:0] REGION_VRAM    = 4'h6;
    localparam logic [3:0] REGION_ROM_LO  = 4'h8;
    localparam logic [3:0] REGION_ROM_HI  = 4'hD;
    localparam logic [3:0] REGION_SRAM    = 4'hE;

    // Wait-control bit that enables the prefetch buffer.
    localparam int PREFETCH_EN_BIT = 14;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOOP,
        BK_DONE
    } bwsc_state_t;

    // One classified access, as handed from front to back.
    typedef struct packed {
        logic        stall_en;
        logic [4:0]  wait_cyc;
        logic [3:0]  s16;
        logic [3:0]  n16;
        logic [31:0] pc;
    } bwsc_entry_t;

    function automatic logic [4:0] nonseq_wait(input logic [1:0] sel);
        logic [4:0] val;
        case (sel)
            2'd0:    val = 5'd4;
            2'd1:    val = 5'd3;
            2'd2:    val = 5'd2;
            default: val = 5'd8;
        endcase
        return val;
    endfunction

    function automatic logic [4:0] seq_wait(input logic [1:0] bank, input logic sel);
        logic [4:0] val;
        if (sel) begin
            val = 5'd1;
        end else begin
            case (bank)
                2'd0:    val = 5'd2;
                2'd1:    val = 5'd4;
                default: val = 5'd8;
            endcase
        end
        return val;
    endfunction

    // Cost of one access to a region, for the given width and cycle kind.
    function automatic logic [4:0] region_cost(input logic [3:0]  region,
                                               input logic        word,
                                               input logic        seq,
                                               input logic [15:0] wc);
        logic [1:0] bank;
        logic [1:0] nsel;
        logic       ssel;
        logic [4:0] n;
        logic [4:0] s;
        logic [4:0] cost;
        bank = region[2:1];
        case (bank)
            2'd0: begin
                nsel = wc[3:2];
                ssel = wc[4];
            end
            2'd1: begin
                nsel = wc[6:5];
                ssel = wc[7];
            end
            default: begin
                nsel = wc[9:8];
                ssel = wc[10];
            end
        endcase
        n = nonseq_wait(nsel);
        s = seq_wait(bank, ssel);
        unique case (region) inside
            REGION_EWRAM: begin
                cost = word ? 5'd6 : 5'd3;
            end
            REGION_PALETTE, REGION_VRAM: begin
                cost = word ? 5'd2 : 5'd1;
            end
            [REGION_ROM_LO:REGION_ROM_HI]: begin
                if (word) begin
                    cost = seq ? ((s << 1) + 5'd2) : (n + s + 5'd2);
                end else begin
                    cost = (seq ? s : n) + 5'd1;
                end
            end
            REGION_SRAM: begin
                cost = nonseq_wait(wc[1:0]) + 5'd1;
            end
            default: begin
                cost = 5'd1;
            end
        endcase
        return cost;
    endfunction

endpackage

// ===== design/bwsc_front.sv =====
// Front end: holds the wait-control register, accepts accesses and classifies them.
// Depends on bwsc_pkg for the entry type and the region cost function.
module bwsc_front
    import bwsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [31:0] s_address,
    input  logic [2:0]  s_access_bytes,
    input  logic        s_is_sequential,
    input  logic [31:0] s_exec_pc,
    input  logic        q_full,
    output logic        push_valid,
    output bwsc_entry_t push_data
);

    logic [15:0] wait_control_reg;
    logic [15:0] wait_control_next;
    logic [4:0]  pc_s_cost;
    logic [4:0]  pc_n_cost;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wait_control_reg <= '0;
        end else begin
            wait_control_reg <= wait_control_next;
        end
    end

    always_comb begin
        wait_control_next = cfg_we ? cfg_wdata : wait_control_reg;
    end

    assign s_ready    = !q_full;
    assign push_valid = s_valid && !q_full;

    // Halfword fetch costs of the code region, used by the stall estimate.
    assign pc_s_cost = region_cost(s_exec_pc[27:24], 1'b0, 1'b1, wait_control_reg);
    assign pc_n_cost = region_cost(s_exec_pc[27:24], 1'b0, 1'b0, wait_control_reg);

    always_comb begin
        push_data.wait_cyc = region_cost(s_address[27:24], s_access_bytes == 3'd4,
                                         s_is_sequential, wait_control_reg);
        // Data below cartridge space, code in cartridge space, prefetch on.
        push_data.stall_en = s_func && (s_address[31:27] == 5'd0) && s_exec_pc[27]
                             && wait_control_reg[PREFETCH_EN_BIT];
        push_data.s16      = 4'(pc_s_cost - 5'd1);
        push_data.n16      = 4'(pc_n_cost - 5'd1);
        push_data.pc       = s_exec_pc;
    end

endmodule

// ===== design/bwsc_queue.sv =====
// Short FIFO of classified accesses between front and back.
// Depends on bwsc_pkg for the entry type and the queue depth.
module bwsc_queue
    import bwsc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  bwsc_entry_t push_data,
    output logic        full,
    input  logic        pop,
    output logic        not_empty,
    output bwsc_entry_t pop_data
);

    bwsc_entry_t          mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;

    function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
        return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/bwsc_back.sv =====
// Back end: runs the prefetch-stall iteration, keeps the prefetch head PC and
// drives the registered result channel. Depends on bwsc_pkg.
module bwsc_back
    import bwsc_pkg::*;
#(
    parameter int MAX_PREFETCH_LOADS = DEF_MAX_PREFETCH_LOADS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_not_empty,
    input  bwsc_entry_t q_data,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_cycles
);

    localparam int LD_W  = $clog2(MAX_PREFETCH_LOADS + 1);
    localparam int ML_W  = LD_W + 4;
    localparam int SUM_W = LD_W + 4;

    bwsc_state_t        state_reg, state_next;
    logic [4:0]         wait_reg, wait_next;
    logic [3:0]         s16_reg, s16_next;
    logic [3:0]         n16_reg, n16_next;
    logic [31:0]        pc_reg, pc_next;
    logic [4:0]         stall_reg, stall_next;
    logic [LD_W-1:0]    loads_reg, loads_next;
    logic [2:0]         prev_reg, prev_next;
    logic signed [ML_W-1:0] budget_reg, budget_next;
    logic [6:0]         res_reg, res_next;
    logic [31:0]        head_reg, head_next;
    logic               m_valid_reg, m_valid_next;
    logic [6:0]         m_cycles_reg, m_cycles_next;

    logic [31:0]        distance;
    logic [2:0]         prev_calc;
    logic               keep_going;
    logic [4:0]         wait_max;
    logic [7:0]         res_wide;
    logic [SUM_W-1:0]   load_sum;

    assign m_valid  = m_valid_reg;
    assign m_cycles = m_cycles_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wait_reg      <= wait_next;
        s16_reg       <= s16_next;
        n16_reg       <= n16_next;
        pc_reg        <= pc_next;
        stall_reg     <= stall_next;
        loads_reg     <= loads_next;
        prev_reg      <= prev_next;
        budget_reg    <= budget_next;
        res_reg       <= res_next;
        m_cycles_reg  <= m_cycles_next;
    end

    // Earlier loads still in the buffer count only when the head is close ahead.
    assign distance  = head_reg - q_data.pc;
    assign prev_calc = (distance[31:4] == '0) ? distance[3:1] : 3'd0;

    assign keep_going = (stall_reg < wait_reg) &&
                        ($signed({{(ML_W - LD_W){1'b0}}, loads_reg}) < budget_reg);
    assign wait_max   = (stall_reg > wait_reg) ? stall_reg : wait_reg;
    assign res_wide   = {3'b0, wait_max} - {4'b0, n16_reg} + {4'b0, s16_reg}
                        - {3'b0, stall_reg};
    assign load_sum   = SUM_W'(loads_reg) + SUM_W'(prev_reg) - SUM_W'(1);

    always_comb begin
        state_next     = state_reg;
        wait_next      = wait_reg;
        s16_next       = s16_reg;
        n16_next       = n16_reg;
        pc_next        = pc_reg;
        stall_next     = stall_reg;
        loads_next     = loads_reg;
        prev_next      = prev_reg;
        budget_next    = budget_reg;
        res_next       = res_reg;
        head_next      = head_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_cycles_next  = m_cycles_reg;
        q_pop          = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_not_empty) begin
                    q_pop          = 1'b1;
                    wait_next      = q_data.wait_cyc;
                    s16_next       = q_data.s16;
                    n16_next       = q_data.n16;
                    pc_next        = q_data.pc;
                    prev_next      = prev_calc;
                    budget_next    = ML_W'(MAX_PREFETCH_LOADS)
                                     - $signed({{(ML_W - 3){1'b0}}, prev_calc});
                    stall_next     = {1'b0, q_data.s16} + 5'd1;
                    loads_next     = LD_W'(1);
                    res_next       = {2'b0, q_data.wait_cyc};
                    state_next     = q_data.stall_en ? BK_LOOP : BK_DONE;
                end
            end
            BK_LOOP: begin
                if (keep_going) begin
                    stall_next = stall_reg + {1'b0, s16_reg};
                    loads_next = loads_reg + 1'b1;
                end else begin
                    head_next  = pc_reg + {{(32 - SUM_W - 1){1'b0}}, load_sum, 1'b0};
                    res_next   = res_wide[6:0];
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_cycles_next = res_reg;
                    state_next    = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

endmodule

// ===== design/bus_wait_state_cycle_calculator.sv =====
// Top level of the bus wait-state cycle calculator: front end, queue and back end.
// Depends on bwsc_pkg, bwsc_front, bwsc_queue and bwsc_back.
//
//   Channel   Direction  Handshake            Beat contents
//   s_        in         s_valid / s_ready    func, address, access_bytes, is_sequential, exec_pc
//   m_        out        m_valid / m_ready    cycles (7-bit signed)
//   cfg_      in         cfg_we (no wait)     wait_control (16 bits)
//
// An access without a prefetch stall goes from idle straight to the done state in the
// back end; a stalled data access runs the stall loop in between, which adds one
// prefetch load per cycle, up to MAX_PREFETCH_LOADS loads in all.
// Reset (aresetn low, synchronous) clears wait_control, the prefetch head PC,
// the queue and the result valid flag; there is no clearing pass.
// The front takes a new beat whenever the two-entry queue has room, so it keeps
// accepting while the back iterates or while a finished result waits on m_ready.
module bus_wait_state_cycle_calculator
    import bwsc_pkg::*;
#(
    parameter int MAX_PREFETCH_LOADS = DEF_MAX_PREFETCH_LOADS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic [31:0]        s_address,
    input  logic [2:0]         s_access_bytes,
    input  logic               s_is_sequential,
    input  logic [31:0]        s_exec_pc,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [6:0]  m_cycles
);

    logic        q_full;
    logic        q_push;
    bwsc_entry_t q_push_data;
    logic        q_pop;
    logic        q_not_empty;
    bwsc_entry_t q_pop_data;
    logic [6:0]  cycles_raw;

    // The front classifies each beat: base cost of the data access, the halfword
    // fetch costs of the code region, and whether the prefetch stall applies.
    bwsc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_address       (s_address),
        .s_access_bytes  (s_access_bytes),
        .s_is_sequential (s_is_sequential),
        .s_exec_pc       (s_exec_pc),
        .q_full          (q_full),
        .push_valid      (q_push),
        .push_data       (q_push_data)
    );

    // The queue decouples classification from the iterative stall estimate.
    bwsc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_pop_data)
    );

    // The back end owns the prefetch head PC, so the distance to the head is
    // measured only once every earlier access has updated it.
    bwsc_back #(
        .MAX_PREFETCH_LOADS (MAX_PREFETCH_LOADS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_data      (q_pop_data),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cycles    (cycles_raw)
    );

    assign m_cycles = $signed(cycles_raw);

endmodule

// ===== tb/bus_wait_state_cycle_calculator_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bus_wait_state_cycle_calculator: directed and random accesses
// are predicted in SystemVerilog and compared beat by beat with the result channel.
// Depends on bwsc_pkg and the bus_wait_state_cycle_calculator RTL.
module bus_wait_state_cycle_calculator_test;
    import bwsc_pkg::*;

    localparam int          PREFETCH_LOADS = DEF_MAX_PREFETCH_LOADS;
    localparam logic        FUNC_PLAIN     = 1'b0;
    localparam logic        FUNC_STALL     = 1'b1;
    localparam logic [31:0] CART_BASE      = 32'h0800_0000;
    localparam logic [15:0] PREFETCH_ON    = 16'h4000;
    localparam logic [2:0]  WORD_BYTES     = 3'd4;
    // Settling margin after a drain, scaled with the prefetch load limit.
    localparam int          SETTLE_CYCLES  = PREFETCH_LOADS + 6;
    localparam int          RANDOM_PHASES  = 6;
    localparam int          PHASE_ITEMS    = 215;
    localparam int          HOLD_CYCLES    = 150;
    localparam int unsigned CYCLE_LIMIT    = 400000;

    // One access as offered on the input channel.
    typedef struct {
        logic        func;
        logic [31:0] address;
        logic [2:0]  bytes;
        logic        seq;
        logic [31:0] exec_pc;
    } access_t;

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               cfg_we          = 1'b0;
    logic [15:0]        cfg_wdata       = 16'h0000;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic               s_func          = 1'b0;
    logic [31:0]        s_address       = 32'h0;
    logic [2:0]         s_access_bytes  = 3'd0;
    logic               s_is_sequential = 1'b0;
    logic [31:0]        s_exec_pc       = 32'h0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic signed [6:0]  m_cycles;

    bus_wait_state_cycle_calculator dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_address       (s_address),
        .s_access_bytes  (s_access_bytes),
        .s_is_sequential (s_is_sequential),
        .s_exec_pc       (s_exec_pc),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cycles        (m_cycles)
    );

    // Predictor state: our own copy of the wait-control register and of the
    // last prefetched PC, both updated only when a beat is accepted or written.
    logic [15:0]       wait_ctl = 16'h0000;
    logic [31:0]       head_pc  = 32'h0;

    access_t           pending_accesses[$];
    logic signed [6:0] expected_cycles[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    bit          hold_armed     = 1'b0;
    int unsigned accepted_beats = 0;
    int unsigned checked_beats  = 0;
    int unsigned stalled_beats  = 0;
    int unsigned setting_count  = 1;
    int unsigned fail_count     = 0;
    int unsigned cycle_count    = 0;
    logic [31:0] pc_cursor      = 32'h0800_0000;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Cost prediction
    // ------------------------------------------------------------------

    // Nonsequential wait of a two-bit wait-control field.
    function automatic int nonseq_cycles(logic [1:0] sel);
        int val;
        case (sel)
            2'd0:    val = 4;
            2'd1:    val = 3;
            2'd2:    val = 2;
            default: val = 8;
        endcase
        return val;
    endfunction

    // Plain cost of one access under the current wait-control setting.
    function automatic int access_cost(logic [31:0] addr, bit word, bit seq);
        logic [3:0] region;
        int         bank;
        int         n_cost;
        int         s_cost;
        int         cost;
        region = addr[27:24];
        if (region >= REGION_ROM_LO && region <= REGION_ROM_HI) begin
            // Each ROM bank covers two regions and owns three wait-control bits.
            bank   = (int'(region) - int'(REGION_ROM_LO)) / 2;
            n_cost = nonseq_cycles(wait_ctl[2 + 3 * bank +: 2]);
            if (wait_ctl[4 + 3 * bank]) begin
                s_cost = 1;
            end else begin
                case (bank)
                    0:       s_cost = 2;
                    1:       s_cost = 4;
                    default: s_cost = 8;
                endcase
            end
            if (word) begin
                cost = seq ? (2 * s_cost + 2) : (n_cost + s_cost + 2);
            end else begin
                cost = (seq ? s_cost : n_cost) + 1;
            end
        end else if (region == REGION_SRAM) begin
            cost = nonseq_cycles(wait_ctl[1:0]) + 1;
        end else if (region == REGION_EWRAM) begin
            cost = word ? 6 : 3;
        end else if (region == REGION_PALETTE || region == REGION_VRAM) begin
            cost = word ? 2 : 1;
        end else begin
            cost = 1;
        end
        return cost;
    endfunction

    // Full cost of an accepted beat. A stall-function data access below cartridge
    // space, made while code runs from cartridge space with prefetch enabled, is
    // charged the prefetch stall, which also moves the prefetch head forward.
    function automatic logic signed [6:0] cost_with_stall(access_t a);
        int          cost;
        int          prev;
        int          load_budget;
        int          s16;
        int          n16;
        int          n_to_s;
        int          stall;
        int          loads;
        logic [31:0] gap;
        cost = access_cost(a.address, a.bytes == WORD_BYTES, a.seq);
        if (a.func == FUNC_STALL && a.address < CART_BASE &&
            a.exec_pc[27:24] >= REGION_ROM_LO && wait_ctl[PREFETCH_EN_BIT]) begin
            stalled_beats++;
            prev        = 0;
            load_budget = PREFETCH_LOADS;
            // Loads already buffered ahead of the PC count only when the head is near.
            gap = head_pc - a.exec_pc;
            if (gap < 32'd16) begin
                prev        = int'(gap >> 1);
                load_budget = load_budget - prev;
            end
            s16    = access_cost(a.exec_pc, 1'b0, 1'b1) - 1;
            n16    = access_cost(a.exec_pc, 1'b0, 1'b0) - 1;
            n_to_s = n16 - s16 + 1;
            stall  = s16 + 1;
            loads  = 1;
            while (stall < cost && loads < load_budget) begin
                stall += s16;
                loads++;
            end
            head_pc = a.exec_pc + 32'(2 * (loads + prev - 1));
            if (stall > cost) begin
                cost = stall;
            end
            cost = cost - n_to_s - (stall - 1);
        end
        return 7'(cost);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_access(logic func, logic [31:0] addr, logic [2:0] bytes,
                                logic seq, logic [31:0] pc);
        access_t a;
        a.func    = func;
        a.address = addr;
        a.bytes   = bytes;
        a.seq     = seq;
        a.exec_pc = pc;
        pending_accesses.push_back(a);
    endtask

    // Mostly real widths, now and then any 3-bit value.
    function automatic logic [2:0] random_width();
        int unsigned pick;
        logic [2:0]  bytes;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            bytes = WORD_BYTES;
        end else if (pick < 7) begin
            bytes = 3'd2;
        end else if (pick < 9) begin
            bytes = 3'd1;
        end else begin
            bytes = 3'($urandom_range(0, 7));
        end
        return bytes;
    endfunction

    // Most random beats look like real code: a data access below cartridge
    // space while the PC walks through cartridge space in small steps, which
    // keeps the prefetch head within reach. The rest are accesses of either
    // function to any region, and pure noise.
    task automatic queue_random_access();
        int unsigned kind;
        logic [31:0] addr;
        logic [31:0] pc;
        logic        func;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
            if ($urandom_range(0, 7) == 0) begin
                pc_cursor = {4'($urandom), 4'($urandom_range(8, 15)), 23'($urandom), 1'b0};
            end else if ($urandom_range(0, 4) == 0) begin
                pc_cursor = pc_cursor - 32'(2 * $urandom_range(0, 4));
            end else begin
                pc_cursor = pc_cursor + 32'(2 * $urandom_range(0, 9));
            end
            addr = {4'h0, 4'($urandom_range(0, 7)), 24'($urandom)};
            pc   = pc_cursor;
            func = ($urandom_range(0, 9) != 0) ? FUNC_STALL : FUNC_PLAIN;
        end else if (kind < 8) begin
            addr = {4'($urandom), 4'($urandom_range(0, 15)), 24'($urandom)};
            pc   = {4'($urandom), 4'($urandom_range(0, 15)), 24'($urandom)};
            func = 1'($urandom);
        end else begin
            addr = $urandom;
            pc   = $urandom;
            func = 1'($urandom);
        end
        queue_access(func, addr, random_width(), 1'($urandom), pc);
    endtask

    // Wait until every queued beat is accepted and every result has come back.
    // The check runs between edges, after the driver has settled for the cycle.
    task automatic wait_until_drained();
        @(negedge aclk);
        while (pending_accesses.size() != 0 || s_valid || expected_cycles.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // The block must be idle; the register takes the value at the next edge.
    task automatic write_wait_control(logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        wait_ctl  = value;
        setting_count++;
    endtask

    // ------------------------------------------------------------------
    // Input driver: offers queued beats, holding each until accepted, and
    // predicts the result of a beat at the edge that accepts it.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        access_t taken;
        access_t next_beat;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                taken.func    = s_func;
                taken.address = s_address;
                taken.bytes   = s_access_bytes;
                taken.seq     = s_is_sequential;
                taken.exec_pc = s_exec_pc;
                expected_cycles.push_back(cost_with_stall(taken));
                accepted_beats++;
            end
            if (!s_valid || s_ready) begin
                if (pending_accesses.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    next_beat = pending_accesses.pop_front();
                    s_valid         <= 1'b1;
                    s_func          <= next_beat.func;
                    s_address       <= next_beat.address;
                    s_access_bytes  <= next_beat.bytes;
                    s_is_sequential <= next_beat.seq;
                    s_exec_pc       <= next_beat.exec_pc;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result ready: random stalls, plus one long hold-off when armed so the
    // internal queue fills and the block stops taking input beats.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        int unsigned hold_left;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            hold_left = 0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_armed) begin
            hold_armed = 1'b0;
            hold_left  = HOLD_CYCLES - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: every accepted result beat is matched against the
    // oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        logic signed [6:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_cycles.size() == 0) begin
                $error("cycles: no result expected, got %0d", m_cycles);
                fail_count++;
            end else begin
                want = expected_cycles.pop_front();
                if (m_cycles !== want) begin
                    $error("cycles: expected %0d, got %0d", want, m_cycles);
                    fail_count++;
                end
                checked_beats++;
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : sequencer
        int unsigned  phase;
        logic [15:0]  setting;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Sender idles rarely and the receiver often for the first part.
        send_idle_pct = 11;
        recv_idle_pct = 46;

        // Directed beats under the reset setting: every region but 0xB, word and
        // halfword, odd widths, and stall requests with prefetch disabled.
        queue_access(FUNC_PLAIN, 32'h0000_0000, 3'd4, 1'b0, 32'h0000_0000);
        queue_access(FUNC_PLAIN, 32'h0100_0000, 3'd2, 1'b0, 32'h0000_0000);
        queue_access(FUNC_PLAIN, 32'h0200_0000, 3'd4, 1'b1, 32'h0000_0000);
        queue_access(FUNC_PLAIN, 32'h02FF_FFFF, 3'd1, 1'b0, 32'h0000_0000);
        queue_access(FUNC_PLAIN, 32'h03FF_FFFC, 3'd4, 1'b0, 32'h0000_0000);
        queue_access(FUNC_PLAIN, 32'h0400_0000, 3'd2, 1'b1, 32'h0000_0000);
        queue_access(FUNC_PLAIN, 32'h0500_0000, 3'd4, 1'b0, 32'h0000_0000);
        queue_access(FUNC_PLAIN, 32'h0600_0000, 3'd2, 1'b0, 32'h0000_0000);
        queue_access(FUNC_PLAIN, 32'h0700_0000, 3'd4, 1'b0, 32'h0000_0000);
        queue_access(FUNC_PLAIN, 32'h0800_0000, 3'd4, 1'b0, 32'h0000_0000);
        queue_access(FUNC_PLAIN, 32'h0900_0000, 3'd4, 1'b1, 32'h0000_0000);
        queue_access(FUNC_PLAIN, 32'h0A00_0000, 3'd2, 1'b1, 32'h0000_0000);
        queue_access(FUNC_PLAIN, 32'h0C00_0000, 3'd0, 1'b0, 32'h0000_0000);
        queue_access(FUNC_PLAIN, 32'h0DFF_FFFF, 3'd7, 1'b1, 32'h0000_0000);
        queue_access(FUNC_PLAIN, 32'h0E00_0000, 3'd3, 1'b0, 32'h0000_0000);
        queue_access(FUNC_STALL, 32'hFFFF_FFFF, 3'd5, 1'b1, 32'hFFFF_FFFF);
        queue_access(FUNC_STALL, 32'h0200_0000, 3'd4, 1'b0, 32'h0800_0000);
        wait_until_drained();

        // Prefetch enabled and every wait bit set. The same PC three times
        // walks from a far head, to a near one, to a single-load budget.
        write_wait_control(16'hFFFF);
        queue_access(FUNC_STALL, 32'h0200_0000, 3'd4, 1'b0, 32'h0800_0100);
        queue_access(FUNC_STALL, 32'h0200_0000, 3'd4, 1'b0, 32'h0800_0100);
        queue_access(FUNC_STALL, 32'h0200_0000, 3'd4, 1'b0, 32'h0800_0100);
        queue_access(FUNC_STALL, 32'h0000_0000, 3'd2, 1'b1, 32'h0800_0102);
        // Code running from SRAM and from the unused top region.
        queue_access(FUNC_STALL, 32'h0300_0000, 3'd4, 1'b0, 32'h0E00_0000);
        queue_access(FUNC_STALL, 32'h0200_0000, 3'd4, 1'b0, 32'hFFFF_FFF0);
        // Stall conditions not met: PC below cartridge, plain function,
        // data address in cartridge space.
        queue_access(FUNC_STALL, 32'h07FF_FFFF, 3'd4, 1'b0, 32'h0700_0000);
        queue_access(FUNC_PLAIN, 32'h0200_0000, 3'd4, 1'b0, 32'h0800_0000);
        queue_access(FUNC_STALL, 32'h0800_0000, 3'd4, 1'b0, 32'h0800_0000);
        wait_until_drained();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       setting = PREFETCH_ON;
                1:       setting = 16'($urandom);
                3:       setting = 16'hBFFF;
                5:       setting = 16'hFFFF;
                default: setting = 16'($urandom) | PREFETCH_ON;
            endcase
            write_wait_control(setting);

            // Idling swaps sides at phase 2 and stops from phase 4 on.
            if (phase == 2) begin
                send_idle_pct = 46;
                recv_idle_pct = 11;
            end else if (phase == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // Long receiver hold-off while beats keep coming.
                hold_armed = 1'b1;
            end

            repeat (PHASE_ITEMS) queue_random_access();
            wait_until_drained();
        end

        if (expected_cycles.size() != 0) begin
            $error("cycles: %0d expected results never arrived", expected_cycles.size());
            fail_count++;
        end

        $display("Covered %0d accesses over %0d wait-control settings, %0d with a prefetch stall.",
                 accepted_beats, setting_count, stalled_beats);
        $display("Compared %0d result beats, %0d mismatches.", checked_beats, fail_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
